[hw/rtl/cfd_pkg.sv]
`timescale 1ns / 1ps

package cfd_pkg;

    // Line control characters
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    // Frame layout: payload bytes 2..10 are kept, 11 bytes make a command
    localparam int FRAME_BYTES     = 11;
    localparam int KEEP_FIRST      = 2;
    localparam int KEEP_DEPTH      = 9;
    localparam int KEEP_IDX_W      = $clog2(KEEP_DEPTH);
    localparam int BUFFER_LEN_DEF  = 256;

    localparam int RX_TDATA_W  = 8;
    localparam int CMD_TDATA_W = 72;

    // Decoded command
    typedef struct packed {
        logic [15:0] steer_speed;
        logic [15:0] direction;
        logic [7:0]  odometer;
        logic [7:0]  park;
        logic [7:0]  brake;
        logic [7:0]  speed;
        logic [7:0]  gear;
    } cmd_t;

    // Stream packing, last field (gear) in the lowest bits
    function automatic logic [CMD_TDATA_W-1:0] pack_cmd(input cmd_t c);
        pack_cmd = {c.steer_speed, c.direction, c.odometer, c.park,
                    c.brake, c.speed, c.gear};
    endfunction

endpackage

[hw/rtl/cfd_rx_stage.sv]
`timescale 1ns / 1ps

module cfd_rx_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cfd_pkg::RX_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    input  logic                             consume,
    output logic                             byte_valid,
    output logic [7:0]                       rx_byte
);
    import cfd_pkg::*;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg;

    // Take a new beat whenever the held one is empty or leaving
    assign s_tready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata[7:0];
        end
    end

    assign byte_valid = valid_reg;
    assign rx_byte    = byte_reg;

endmodule

[hw/rtl/cfd_frame_core.sv]
`timescale 1ns / 1ps

module cfd_frame_core #(
    parameter int BUFFER_LEN = cfd_pkg::BUFFER_LEN_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    output logic          cmd_valid,
    output cfd_pkg::cmd_t cmd
);
    import cfd_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_LEN);

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  cr_reg, cr_next;
    logic [7:0]            keep_reg [KEEP_DEPTH];
    logic [CNT_W:0]        count_inc;
    logic                  keep_hit;
    logic [KEEP_IDX_W-1:0] keep_idx;
    logic                  store;

    // Frame tracking
    assign count_inc = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign keep_hit  = (count_reg >= CNT_W'(KEEP_FIRST)) &&
                       (count_reg <  CNT_W'(KEEP_FIRST + KEEP_DEPTH));
    assign keep_idx  = KEEP_IDX_W'(count_reg - CNT_W'(KEEP_FIRST));
    assign store     = step && !cr_reg && (rx_byte != CH_CR);

    always_comb begin
        count_next = count_reg;
        cr_next    = cr_reg;
        if (step) begin
            if (cr_reg) begin
                // LF or not, the frame is over
                count_next = '0;
                cr_next    = 1'b0;
            end else if (rx_byte == CH_CR) begin
                cr_next = 1'b1;
            end else if (count_inc == (CNT_W+1)'(BUFFER_LEN)) begin
                count_next = '0;
            end else begin
                count_next = count_inc[CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cr_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            cr_reg    <= cr_next;
        end
    end

    // Payload bytes 2..10, no reset
    always_ff @(posedge aclk) begin
        if (store && keep_hit) begin
            keep_reg[keep_idx] <= rx_byte;
        end
    end

    // Command decode on CR LF after exactly eleven bytes
    assign cmd_valid = step && cr_reg && (rx_byte == CH_LF) &&
                       (count_reg == CNT_W'(FRAME_BYTES));

    assign cmd.gear        = keep_reg[0];
    assign cmd.speed       = keep_reg[1];
    assign cmd.brake       = keep_reg[2];
    assign cmd.park        = keep_reg[3];
    assign cmd.odometer    = keep_reg[4];
    assign cmd.direction   = {keep_reg[6], keep_reg[5]};
    assign cmd.steer_speed = {keep_reg[8], keep_reg[7]};

    // Checks
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < CNT_W'(BUFFER_LEN - 1) || count_reg == CNT_W'(BUFFER_LEN - 1))
        else $error("byte count beyond buffer length");

    a_cr_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && cr_reg) |=> (count_reg == '0 && !cr_reg))
        else $error("frame not closed after CR");

    a_cmd_len: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_valid |-> (cr_reg && count_reg == CNT_W'(FRAME_BYTES)))
        else $error("command on wrong frame length");

    a_cr_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!step) |=> (cr_reg == $past(cr_reg) && count_reg == $past(count_reg)))
        else $error("frame state moved without a byte");

endmodule

[hw/rtl/cfd_cmd_stage.sv]
`timescale 1ns / 1ps

module cfd_cmd_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  cfd_pkg::cmd_t                    cmd,
    output logic                             free,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cfd_pkg::CMD_TDATA_W-1:0]  m_tdata
);
    import cfd_pkg::*;

    logic                   valid_reg, valid_next;
    logic [CMD_TDATA_W-1:0] data_reg;

    // Slot is free when empty or draining this cycle
    assign free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= pack_cmd(cmd);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

[hw/rtl/crlf_command_frame_decoder.sv]
`timescale 1ns / 1ps
// The LF beat is held in the byte register, then its command in the command register.
// Throughput: one received byte per cycle while the command output is not stalled.
// The rate is set by the combinational frame check between the byte and command registers.
// Reset (aresetn low, synchronous) empties both stages and clears the count and CR flag;
// the kept payload bytes are not reset.
module crlf_command_frame_decoder #(
    parameter int BUFFER_LEN = cfd_pkg::BUFFER_LEN_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cfd_pkg::RX_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] gear, [15:8] speed, [23:16] brake, [31:24] park, [39:32] odometer,
    // [55:40] direction, [71:56] steer_speed
    output logic [cfd_pkg::CMD_TDATA_W-1:0]  m_tdata
);
    import cfd_pkg::*;

    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       out_free;
    logic       advance;
    logic       cmd_valid;
    cmd_t       cmd;

    // Held byte moves on when the command slot can take a result
    assign advance = rx_valid && out_free;

    cfd_rx_stage u_rx (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .consume    (advance),
        .byte_valid (rx_valid),
        .rx_byte    (rx_byte)
    );

    cfd_frame_core #(
        .BUFFER_LEN (BUFFER_LEN)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .rx_byte   (rx_byte),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    cfd_cmd_stage u_cmd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (cmd_valid),
        .cmd      (cmd),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
